### design/rvb_pkg.sv
package rvb_pkg;

   localparam int SAMPLE_WIDTH    = 24;
   localparam int COEF_WIDTH      = 16;
   localparam int PROD_WIDTH      = 42;
   localparam int ACC_WIDTH       = 28;
   localparam int COMB_LINES      = 16;
   localparam int ALLPASS_LINES   = 8;
   localparam int COMB_MEM_DEPTH  = 22232;
   localparam int AP_MEM_DEPTH    = 3218;
   localparam int COMB_ADDR_WIDTH = $clog2(COMB_MEM_DEPTH);
   localparam int AP_ADDR_WIDTH   = $clog2(AP_MEM_DEPTH);
   localparam int COMB_POS_WIDTH  = 11;
   localparam int AP_POS_WIDTH    = 10;

   localparam logic [2:0] REG_ENABLE     = 3'd0;
   localparam logic [2:0] REG_INPUT_GAIN = 3'd1;
   localparam logic [2:0] REG_ROOM_FB    = 3'd2;
   localparam logic [2:0] REG_DAMPING    = 3'd3;
   localparam logic [2:0] REG_WET_DIRECT = 3'd4;
   localparam logic [2:0] REG_WET_CROSS  = 3'd5;
   localparam logic [2:0] REG_MIX_LEVEL  = 3'd6;

   localparam logic [14:0] ONE_Q14 = 15'd16384;

   localparam logic [COMB_POS_WIDTH-1:0] COMB_LEN [COMB_LINES] = '{
      11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617,
      11'd1139, 11'd1211, 11'd1300, 11'd1379, 11'd1445, 11'd1514, 11'd1580, 11'd1640};

   localparam logic [COMB_ADDR_WIDTH-1:0] COMB_BASE [COMB_LINES] = '{
      15'd0,     15'd1116,  15'd2304,  15'd3581,  15'd4937,  15'd6359,  15'd7850,  15'd9407,
      15'd11024, 15'd12163, 15'd13374, 15'd14674, 15'd16053, 15'd17498, 15'd19012, 15'd20592};

   localparam logic [AP_POS_WIDTH-1:0] AP_LEN [ALLPASS_LINES] = '{
      10'd556, 10'd441, 10'd341, 10'd225, 10'd579, 10'd464, 10'd364, 10'd248};

   localparam logic [AP_ADDR_WIDTH-1:0] AP_BASE [ALLPASS_LINES] = '{
      12'd0, 12'd556, 12'd997, 12'd1338, 12'd1563, 12'd2142, 12'd2606, 12'd2970};

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_GAIN, ST_GSAT,
      ST_C_RD, ST_C_MUL, ST_C_ST, ST_C_FB, ST_C_WR,
      ST_A_RD, ST_A_WR,
      ST_W_L, ST_W_R, ST_O_L, ST_O_R, ST_O_FIN, ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] a0;
      logic [COEF_WIDTH-1:0]          b0;
      logic signed [SAMPLE_WIDTH-1:0] a1;
      logic [COEF_WIDTH-1:0]          b1;
   } mac_op_type;

   function automatic logic signed [PROD_WIDTH-1:0] ext(input logic signed [SAMPLE_WIDTH-1:0] v);
      return PROD_WIDTH'(v);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [PROD_WIDTH-1:0] v);
      logic signed [PROD_WIDTH-1:0] hi;
      logic signed [PROD_WIDTH-1:0] lo;
      hi = PROD_WIDTH'(signed'((1 << (SAMPLE_WIDTH - 1)) - 1));
      lo = -hi - PROD_WIDTH'(signed'(1));
      if (v > hi) return hi[SAMPLE_WIDTH-1:0];
      if (v < lo) return lo[SAMPLE_WIDTH-1:0];
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic logic signed [PROD_WIDTH-1:0] q14(input logic signed [PROD_WIDTH-1:0] v);
      logic signed [PROD_WIDTH-1:0] t;
      t = v + PROD_WIDTH'(signed'(8192));
      return t >>> 14;
   endfunction

endpackage

### design/rvb_delay_mem.sv
module rvb_delay_mem #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rvb_mac.sv
module rvb_mac (
   input  logic                                    clock,
   input  rvb_pkg::mac_op_type                     op,
   output logic signed [rvb_pkg::PROD_WIDTH-1:0]   prod
);
   import rvb_pkg::*;

   logic signed [COEF_WIDTH:0]                b0_s;
   logic signed [COEF_WIDTH:0]                b1_s;
   logic signed [SAMPLE_WIDTH+COEF_WIDTH:0]   p0;
   logic signed [SAMPLE_WIDTH+COEF_WIDTH:0]   p1;
   logic signed [PROD_WIDTH-1:0]              prod_ff;
   logic signed [PROD_WIDTH-1:0]              prod_in;

   assign b0_s    = {1'b0, op.b0};
   assign b1_s    = {1'b0, op.b1};
   assign p0      = op.a0 * b0_s;
   assign p1      = op.a1 * b1_s;
   assign prod_in = PROD_WIDTH'(p0) + PROD_WIDTH'(p1);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### design/schroeder_comb_allpass_reverb.sv
// No new sample is accepted until the last result is loaded for output. With reverb
// on, the sequencer walks 16 comb lines (read, multiply, store, feedback, write;
// one shared dual-product MAC) and 8 allpasses (read, write).
// Reset: synchronous; control and configuration registers take their defaults, then a
// clearing pass zeroes every address of both delay memories while no sample is accepted.
module schroeder_comb_allpass_reverb (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [rvb_pkg::SAMPLE_WIDTH-1:0]  req_sample_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [rvb_pkg::SAMPLE_WIDTH-1:0]  rsp_left_sample,
   output logic signed [rvb_pkg::SAMPLE_WIDTH-1:0]  rsp_right_sample,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [2:0]                               csr_index,
   input  logic [15:0]                              csr_data
);
   import rvb_pkg::*;

   localparam int SW = SAMPLE_WIDTH;

   state_type state_ff, state_in;

   logic        enable_ff;
   logic [15:0] input_gain_ff;
   logic [13:0] room_fb_ff;
   logic [14:0] damping_ff;
   logic [15:0] wet_direct_ff;
   logic [15:0] wet_cross_ff;
   logic [14:0] mix_level_ff;

   logic [COMB_ADDR_WIDTH-1:0] clr_ff, clr_in;
   logic [3:0] k_ff, k_in;
   logic [2:0] j_ff, j_in;

   logic signed [SW-1:0] x_ff, x_in;
   logic signed [SW-1:0] g_ff, g_in;
   logic signed [SW-1:0] st_ff, st_in;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic signed [SW-1:0] sum_ff [2];
   logic signed [SW-1:0] sum_in [2];
   logic signed [SW-1:0] wl_ff, wl_in, wr_ff, wr_in;
   logic signed [SW-1:0] outl_ff, outl_in, outr_ff, outr_in;
   logic signed [SW-1:0] store_ff [COMB_LINES];
   logic signed [SW-1:0] store_in [COMB_LINES];
   logic [COMB_POS_WIDTH-1:0] cpos_ff [COMB_LINES];
   logic [COMB_POS_WIDTH-1:0] cpos_in [COMB_LINES];
   logic [AP_POS_WIDTH-1:0] apos_ff [ALLPASS_LINES];
   logic [AP_POS_WIDTH-1:0] apos_in [ALLPASS_LINES];

   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_left_ff, rsp_right_ff;
   logic              rsp_load;

   logic [14:0] d_q, omd_q, m_q, omm_q;

   mac_op_type                    mac_op;
   logic signed [PROD_WIDTH-1:0]  prod;

   logic                       cm_wr_en, cm_rd_en;
   logic [COMB_ADDR_WIDTH-1:0] cm_wr_addr, cm_addr;
   logic [SW-1:0]              cm_wr_data, cm_q;
   logic                       am_wr_en, am_rd_en;
   logic [AP_ADDR_WIDTH-1:0]   am_wr_addr, am_addr;
   logic [SW-1:0]              am_wr_data, am_q;

   logic signed [SW-1:0] t_s, b_s, s_s;

   assign d_q   = (damping_ff > ONE_Q14) ? ONE_Q14 : damping_ff;
   assign omd_q = ONE_Q14 - d_q;
   assign m_q   = (mix_level_ff > ONE_Q14) ? ONE_Q14 : mix_level_ff;
   assign omm_q = ONE_Q14 - m_q;

   assign cm_addr = COMB_BASE[k_ff] + COMB_ADDR_WIDTH'(cpos_ff[k_ff]);
   assign am_addr = AP_BASE[j_ff] + AP_ADDR_WIDTH'(apos_ff[j_ff]);
   assign t_s     = cm_q;
   assign b_s     = am_q;
   assign s_s     = sum_ff[j_ff[2]];

   assign req_stall        = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = rsp_left_ff;
   assign rsp_right_sample = rsp_right_ff;
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   rvb_mac u_mac (
      .clock (clock),
      .op    (mac_op),
      .prod  (prod)
   );

   rvb_delay_mem #(.WIDTH(SW), .DEPTH(COMB_MEM_DEPTH)) u_comb_mem (
      .clock   (clock),
      .wr_en   (cm_wr_en),
      .wr_addr (cm_wr_addr),
      .wr_data (cm_wr_data),
      .rd_en   (cm_rd_en),
      .rd_addr (cm_addr),
      .rd_data (cm_q)
   );

   rvb_delay_mem #(.WIDTH(SW), .DEPTH(AP_MEM_DEPTH)) u_ap_mem (
      .clock   (clock),
      .wr_en   (am_wr_en),
      .wr_addr (am_wr_addr),
      .wr_data (am_wr_data),
      .rd_en   (am_rd_en),
      .rd_addr (am_addr),
      .rd_data (am_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == COMB_ADDR_WIDTH'(COMB_MEM_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = enable_ff ? ST_GAIN : ST_DONE;
         end
         ST_GAIN:  state_in = ST_GSAT;
         ST_GSAT:  state_in = ST_C_RD;
         ST_C_RD:  state_in = ST_C_MUL;
         ST_C_MUL: state_in = ST_C_ST;
         ST_C_ST:  state_in = ST_C_FB;
         ST_C_FB:  state_in = ST_C_WR;
         ST_C_WR:  state_in = (k_ff == 4'(COMB_LINES - 1)) ? ST_A_RD : ST_C_RD;
         ST_A_RD:  state_in = ST_A_WR;
         ST_A_WR:  state_in = (j_ff == 3'(ALLPASS_LINES - 1)) ? ST_W_L : ST_A_RD;
         ST_W_L:   state_in = ST_W_R;
         ST_W_R:   state_in = ST_O_L;
         ST_O_L:   state_in = ST_O_R;
         ST_O_R:   state_in = ST_O_FIN;
         ST_O_FIN: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mac_op     = '0;
      cm_wr_en   = 1'b0;
      cm_rd_en   = 1'b0;
      cm_wr_addr = cm_addr;
      cm_wr_data = sat(ext(g_ff) + q14(prod));
      am_wr_en   = 1'b0;
      am_rd_en   = 1'b0;
      am_wr_addr = am_addr;
      am_wr_data = sat(ext(s_s) + ext(b_s >>> 1));
      unique case (state_ff)
         ST_CLEAR: begin
            cm_wr_en   = 1'b1;
            cm_wr_addr = clr_ff;
            cm_wr_data = '0;
            am_wr_en   = (clr_ff < COMB_ADDR_WIDTH'(AP_MEM_DEPTH));
            am_wr_addr = clr_ff[AP_ADDR_WIDTH-1:0];
            am_wr_data = '0;
         end
         ST_GAIN: begin
            mac_op.a0 = x_ff;
            mac_op.b0 = input_gain_ff;
         end
         ST_C_RD:  cm_rd_en = 1'b1;
         ST_C_MUL: begin
            mac_op.a0 = t_s;
            mac_op.b0 = {1'b0, omd_q};
            mac_op.a1 = store_ff[k_ff];
            mac_op.b1 = {1'b0, d_q};
         end
         ST_C_FB: begin
            mac_op.a0 = st_ff;
            mac_op.b0 = {2'b0, room_fb_ff};
         end
         ST_C_WR:  cm_wr_en = 1'b1;
         ST_A_RD:  am_rd_en = 1'b1;
         ST_A_WR:  am_wr_en = 1'b1;
         ST_W_L: begin
            mac_op.a0 = sum_ff[0];
            mac_op.b0 = wet_direct_ff;
            mac_op.a1 = sum_ff[1];
            mac_op.b1 = wet_cross_ff;
         end
         ST_W_R: begin
            mac_op.a0 = sum_ff[1];
            mac_op.b0 = wet_direct_ff;
            mac_op.a1 = sum_ff[0];
            mac_op.b1 = wet_cross_ff;
         end
         ST_O_L: begin
            mac_op.a0 = x_ff;
            mac_op.b0 = {1'b0, omm_q};
            mac_op.a1 = wl_ff;
            mac_op.b1 = {1'b0, m_q};
         end
         ST_O_R: begin
            mac_op.a0 = x_ff;
            mac_op.b0 = {1'b0, omm_q};
            mac_op.a1 = wr_ff;
            mac_op.b1 = {1'b0, m_q};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      clr_in   = clr_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      x_in     = x_ff;
      g_in     = g_ff;
      st_in    = st_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      wl_in    = wl_ff;
      wr_in    = wr_ff;
      outl_in  = outl_ff;
      outr_in  = outr_ff;
      store_in = store_ff;
      cpos_in  = cpos_ff;
      apos_in  = apos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_sample_in;
               outl_in = req_sample_in;
               outr_in = req_sample_in;
            end
         end
         ST_GSAT: begin
            g_in   = sat(q14(prod));
            k_in   = '0;
            acc_in = '0;
         end
         ST_C_MUL: acc_in = acc_ff + ACC_WIDTH'(t_s);
         ST_C_ST: begin
            st_in           = sat(q14(prod));
            store_in[k_ff]  = sat(q14(prod));
         end
         ST_C_WR: begin
            cpos_in[k_ff] = (cpos_ff[k_ff] == COMB_LEN[k_ff] - 1'b1) ? '0
                                                                     : cpos_ff[k_ff] + 1'b1;
            if (k_ff[2:0] == 3'd7) begin
               sum_in[k_ff[3]] = sat(PROD_WIDTH'(acc_ff));
               acc_in          = '0;
            end
            k_in = k_ff + 1'b1;
            j_in = '0;
         end
         ST_A_WR: begin
            sum_in[j_ff[2]] = sat(ext(b_s) - ext(s_s));
            apos_in[j_ff]   = (apos_ff[j_ff] == AP_LEN[j_ff] - 1'b1) ? '0
                                                                     : apos_ff[j_ff] + 1'b1;
            j_in = j_ff + 1'b1;
         end
         ST_W_R:   wl_in   = sat(q14(prod));
         ST_O_L:   wr_in   = sat(q14(prod));
         ST_O_R:   outl_in = sat(q14(prod));
         ST_O_FIN: outr_in = sat(q14(prod));
         ST_DONE: begin
            if (rsp_load) rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         k_ff          <= '0;
         j_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         enable_ff     <= 1'b0;
         input_gain_ff <= 16'd229;
         room_fb_ff    <= 14'd13763;
         damping_ff    <= 15'd3277;
         wet_direct_ff <= 16'd49152;
         wet_cross_ff  <= 16'd0;
         mix_level_ff  <= 15'd0;
         for (int i = 0; i < COMB_LINES; i++) begin
            store_ff[i] <= '0;
            cpos_ff[i]  <= '0;
         end
         for (int i = 0; i < ALLPASS_LINES; i++) begin
            apos_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
         store_ff     <= store_in;
         cpos_ff      <= cpos_in;
         apos_ff      <= apos_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ENABLE:     enable_ff     <= csr_data[0];
               REG_INPUT_GAIN: input_gain_ff <= csr_data;
               REG_ROOM_FB:    room_fb_ff    <= csr_data[13:0];
               REG_DAMPING:    damping_ff    <= csr_data[14:0];
               REG_WET_DIRECT: wet_direct_ff <= csr_data;
               REG_WET_CROSS:  wet_cross_ff  <= csr_data;
               REG_MIX_LEVEL:  mix_level_ff  <= csr_data[14:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      g_ff    <= g_in;
      st_ff   <= st_in;
      acc_ff  <= acc_in;
      sum_ff  <= sum_in;
      wl_ff   <= wl_in;
      wr_ff   <= wr_in;
      outl_ff <= outl_in;
      outr_ff <= outr_in;
      if (rsp_load) begin
         rsp_left_ff  <= outl_ff;
         rsp_right_ff <= outr_ff;
      end
   end

endmodule

### bench/reverb_checker.sv
module reverb_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [rvb_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [rvb_pkg::SAMPLE_WIDTH-1:0] rsp_left_sample,
   input  logic signed [rvb_pkg::SAMPLE_WIDTH-1:0] rsp_right_sample,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [2:0]                              csr_index,
   input  logic [15:0]                             csr_data,
   output int                                      pending,
   output int                                      errors
);
   import rvb_pkg::*;

   typedef struct {
      longint left;
      longint right;
   } stereo_pair_type;

   stereo_pair_type expected_pairs[$];

   logic    enable_r;
   longint  gain_r, room_r, damp_r, wet_dir_r, wet_x_r, mix_r;
   longint  comb_mem [COMB_MEM_DEPTH];
   longint  ap_mem [AP_MEM_DEPTH];
   longint  comb_lp [COMB_LINES];
   int      comb_pos [COMB_LINES];
   int      ap_pos [ALLPASS_LINES];

   function automatic longint clip(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint round14(input longint v);
      return (v + 8192) >>> 14;
   endfunction

   task automatic reverb_sample(input longint x);
      stereo_pair_type p;
      longint g, d, m, t, st, acc, b;
      longint s [2];
      longint w [2];
      int k, addr;
      if (!enable_r) begin
         p.left = x;
         p.right = x;
      end else begin
         d = (damp_r > 16384) ? 16384 : damp_r;
         m = (mix_r > 16384) ? 16384 : mix_r;
         g = clip(round14(x * gain_r));
         for (int ch = 0; ch < 2; ch++) begin
            acc = 0;
            for (int i = 0; i < 8; i++) begin
               k = ch * 8 + i;
               addr = int'(COMB_BASE[k]) + comb_pos[k];
               t = comb_mem[addr];
               st = clip(round14(t * (16384 - d) + comb_lp[k] * d));
               comb_lp[k] = st;
               comb_mem[addr] = clip(g + round14(st * room_r));
               comb_pos[k] = (comb_pos[k] + 1 >= int'(COMB_LEN[k])) ? 0 : comb_pos[k] + 1;
               acc += t;
            end
            s[ch] = clip(acc);
         end
         for (int ch = 0; ch < 2; ch++) begin
            for (int i = 0; i < 4; i++) begin
               k = ch * 4 + i;
               addr = int'(AP_BASE[k]) + ap_pos[k];
               b = ap_mem[addr];
               ap_mem[addr] = clip(s[ch] + (b >>> 1));
               ap_pos[k] = (ap_pos[k] + 1 >= int'(AP_LEN[k])) ? 0 : ap_pos[k] + 1;
               s[ch] = clip(b - s[ch]);
            end
         end
         w[0] = clip(round14(s[0] * wet_dir_r + s[1] * wet_x_r));
         w[1] = clip(round14(s[1] * wet_dir_r + s[0] * wet_x_r));
         p.left = clip(round14(x * (16384 - m) + w[0] * m));
         p.right = clip(round14(x * (16384 - m) + w[1] * m));
      end
      expected_pairs.push_back(p);
   endtask

   assign pending = expected_pairs.size();

   always @(posedge clock) begin
      stereo_pair_type p;
      if (reset) begin
         errors = 0;
         enable_r = 1'b0;
         gain_r = 229;
         room_r = 13763;
         damp_r = 3277;
         wet_dir_r = 49152;
         wet_x_r = 0;
         mix_r = 0;
         foreach (comb_mem[i]) comb_mem[i] = 0;
         foreach (ap_mem[i]) ap_mem[i] = 0;
         foreach (comb_lp[i]) comb_lp[i] = 0;
         foreach (comb_pos[i]) comb_pos[i] = 0;
         foreach (ap_pos[i]) ap_pos[i] = 0;
         expected_pairs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ENABLE:     enable_r = csr_data[0];
               REG_INPUT_GAIN: gain_r = csr_data;
               REG_ROOM_FB:    room_r = csr_data[13:0];
               REG_DAMPING:    damp_r = csr_data[14:0];
               REG_WET_DIRECT: wet_dir_r = csr_data;
               REG_WET_CROSS:  wet_x_r = csr_data;
               REG_MIX_LEVEL:  mix_r = csr_data[14:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               $error("unexpected beat left_sample=%0d right_sample=%0d",
                      rsp_left_sample, rsp_right_sample);
               errors++;
            end else begin
               p = expected_pairs.pop_front();
               if (longint'(rsp_left_sample) != p.left) begin
                  $error("left_sample expected %0d actual %0d", p.left, rsp_left_sample);
                  errors++;
               end
               if (longint'(rsp_right_sample) != p.right) begin
                  $error("right_sample expected %0d actual %0d", p.right, rsp_right_sample);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            reverb_sample(longint'(req_sample_in));
      end
   end
endmodule

### bench/schroeder_comb_allpass_reverb_test.sv
module schroeder_comb_allpass_reverb_test;
   import rvb_pkg::*;

   localparam int IDLE_LIMIT = 300000;
   localparam int SETTLE = 120;
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_left_sample, rsp_right_sample;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = REG_ENABLE;
   logic [15:0] csr_data = '0;

   int pending, errors;
   int tx_pct = 0, rx_pct = 0;
   int idle_cycles = 0;
   bit hold_go = 0;

   always #10 clock = ~clock;

   schroeder_comb_allpass_reverb u_top (.*);

   reverb_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 0;
            repeat (600) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rx_pct);
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] x);
      if ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_sample_in <= x;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return SAMPLE_WIDTH'($signed($urandom_range(0, 2000)) - 1000);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // bypass with reset settings
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(24'sh000000);
      send_sample(-24'sd1);
      drain();

      write_reg(REG_ENABLE, 16'd1);
      for (int i = 0; i < 4; i++) send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(24'sd12345);
      drain();

      write_reg(REG_INPUT_GAIN, 16'hFFFF);
      write_reg(REG_ROOM_FB, 16'h3FFF);
      write_reg(REG_DAMPING, 16'h7FFF);
      write_reg(REG_WET_DIRECT, 16'hFFFF);
      write_reg(REG_WET_CROSS, 16'hFFFF);
      write_reg(REG_MIX_LEVEL, 16'h7FFF);
      write_reg(REG_UNMAPPED, 16'hFFFF);
      for (int i = 0; i < 5; i++) send_sample(i[0] ? 24'sh800000 : 24'sh7FFFFF);
      drain();

      write_reg(REG_DAMPING, 16'd0);
      write_reg(REG_MIX_LEVEL, 16'd16384);
      write_reg(REG_ROOM_FB, 16'd0);
      write_reg(REG_INPUT_GAIN, 16'd0);
      for (int i = 0; i < 4; i++) send_sample(pick_sample());
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         tx_pct = (ph < 3) ? 29 : (ph < 6) ? 74 : 0;
         rx_pct = (ph < 3) ? 74 : (ph < 6) ? 29 : 0;
         write_reg(REG_ENABLE, 16'($urandom_range(5) != 0));
         write_reg(REG_INPUT_GAIN, pick_coef());
         write_reg(REG_ROOM_FB, pick_coef());
         write_reg(REG_DAMPING, pick_coef());
         write_reg(REG_WET_DIRECT, pick_coef());
         write_reg(REG_WET_CROSS, pick_coef());
         write_reg(REG_MIX_LEVEL, pick_coef());
         if (ph == 2) write_reg(REG_UNMAPPED, pick_coef());
         for (int i = 0; i < 125; i++) begin
            if (ph == 1 && i == 10) hold_go = 1;
            if (ph == 4 && i == 60) drain();
            send_sample(pick_sample());
         end
         drain();
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
